// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ctri_pkg.sv -----
`default_nettype none
package ctri_pkg;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_MOVE    = 2'd2;
    localparam logic [1:0] OP_RAY     = 2'd3;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;
    localparam logic [30:0] HEIGHT_RESET = 31'd131072;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [30:0]        max_dist;
    } ctri_request_t;

    typedef struct packed {
        logic        ok;
        logic        hit;
        logic [30:0] distance;
    } ctri_result_t;

    // classified work handed from front to back
    typedef struct packed {
        logic               ok;
        logic               ray;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [30:0]        max_dist;
    } ctri_job_t;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ctri_front.sv -----
`default_nettype none
module ctri_front #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire ctri_pkg::ctri_request_t request,
    input  wire logic [29:0]            half_h,
    input  wire logic                   q_full,
    output logic                        push,
    output ctri_pkg::ctri_job_t         push_job
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic signed [31:0] base_x_mem [NUM_SLOTS];
    logic signed [31:0] base_y_mem [NUM_SLOTS];
    logic signed [31:0] base_z_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] act_reg;

    logic          accept;
    logic [IW-1:0] idx;
    logic          in_range;
    logic          active;
    logic          wr_base;

    logic               s1_vld_reg;
    logic               s1_ok_reg;
    logic               s1_ray_reg;
    ctri_pkg::ctri_request_t s1_req_reg;
    logic signed [31:0] bx_reg;
    logic signed [31:0] by_reg;
    logic signed [31:0] bz_reg;
    logic signed [30:0] hh_s;

    assign busy     = s1_vld_reg | q_full;
    assign accept   = start & ~busy;
    assign idx      = IW'(request.slot);
    assign in_range = 32'(request.slot) < 32'(NUM_SLOTS);
    assign active   = in_range && act_reg[idx];
    assign wr_base  = accept && in_range &&
                      ((request.opcode == ctri_pkg::OP_CREATE) ||
                       ((request.opcode == ctri_pkg::OP_MOVE) && active));

    // table storage, synchronous read
    always_ff @(posedge clk) begin
        if (wr_base) begin
            base_x_mem[idx] <= request.pos_x;
            base_y_mem[idx] <= request.pos_y;
            base_z_mem[idx] <= request.pos_z;
        end
        bx_reg <= base_x_mem[idx];
        by_reg <= base_y_mem[idx];
        bz_reg <= base_z_mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            act_reg    <= '0;
            s1_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= accept;
            if (accept && in_range) begin
                if (request.opcode == ctri_pkg::OP_CREATE) begin
                    act_reg[idx] <= 1'b1;
                end else if (request.opcode == ctri_pkg::OP_DESTROY) begin
                    act_reg[idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            s1_req_reg <= request;
            s1_ray_reg <= (request.opcode == ctri_pkg::OP_RAY) && active;
            unique case (request.opcode)
                ctri_pkg::OP_CREATE:  s1_ok_reg <= in_range;
                ctri_pkg::OP_DESTROY: s1_ok_reg <= in_range;
                ctri_pkg::OP_MOVE:    s1_ok_reg <= active;
                ctri_pkg::OP_RAY:     s1_ok_reg <= active;
                default:              s1_ok_reg <= 1'b0;
            endcase
        end
    end

    // offsets from the capsule center axis
    assign hh_s = {1'b0, half_h};
    assign push = s1_vld_reg;
    always_comb begin
        push_job          = '0;
        push_job.ok       = s1_ok_reg;
        push_job.ray      = s1_ray_reg;
        push_job.ox       = ctri_pkg::sat32(52'(s1_req_reg.origin_x) - 52'(bx_reg));
        push_job.oy       = ctri_pkg::sat32(52'(s1_req_reg.origin_y) - 52'(by_reg)
                                            - 52'(hh_s));
        push_job.oz       = ctri_pkg::sat32(52'(s1_req_reg.origin_z) - 52'(bz_reg));
        push_job.dx       = s1_req_reg.dir_x;
        push_job.dy       = s1_req_reg.dir_y;
        push_job.dz       = s1_req_reg.dir_z;
        push_job.max_dist = s1_req_reg.max_dist;
    end

endmodule
`default_nettype wire

// ----- rtl/ctri_fifo.sv -----
`default_nettype none
module ctri_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ctri_pkg::ctri_job_t push_job,
    input  wire logic                pop,
    output ctri_pkg::ctri_job_t      head_job,
    output logic                     empty,
    output logic                     full
);

    localparam int PW = $clog2(ctri_pkg::QUEUE_DEPTH);

    ctri_pkg::ctri_job_t mem_reg [ctri_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   cnt_reg;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == (PW+1)'(ctri_pkg::QUEUE_DEPTH));
    assign head_job = mem_reg[rp_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ctri_div.sv -----
`default_nettype none
module ctri_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [33:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [34:0]      quo
);

    // (num * 2^16) / den, toward zero, magnitude saturated at 2^33
    localparam int STEPS = 50;
    localparam logic [49:0] QMAX = 50'h2_0000_0000;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [49:0] dq_reg;
    logic [31:0] d_reg;
    logic        neg_reg;
    logic        done_reg;
    logic signed [34:0] quo_reg;

    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_sub;
    logic [49:0] dq_new;
    logic [33:0] mag;
    logic [33:0] nmag;

    assign rem_sh  = {rem_reg, dq_reg[49]};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign dq_new  = {dq_reg[48:0], ge};
    assign mag     = (dq_new > QMAX) ? QMAX[33:0] : dq_new[33:0];
    assign nmag    = num[33] ? 34'(-num) : 34'(num);

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= '0;
            dq_reg  <= {nmag, 16'd0};
            d_reg   <= den[31] ? 32'(-den) : 32'(den);
            neg_reg <= num[33] ^ den[31];
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            dq_reg  <= dq_new;
            if (cnt_reg == 6'(STEPS - 1)) begin
                quo_reg <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ctri_sqrt.sv -----
`default_nettype none
module ctri_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] rad,
    output logic             done,
    output logic [31:0]      root
);

    // floor square root, two radicand bits per step
    localparam int STEPS = 32;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic        done_reg;

    logic [35:0] rem_t;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] rem_sub;

    assign rem_t   = {rem_reg, rad_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = rem_t >= trial;
    assign rem_sub = rem_t - trial;

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= ge ? rem_sub[33:0] : rem_t[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ctri_back.sv -----
`default_nettype none
module ctri_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire ctri_pkg::ctri_job_t q_job,
    output logic                     pop,
    input  wire logic [30:0]         radius,
    input  wire logic [29:0]         half_h,
    output logic                     done,
    output ctri_pkg::ctri_result_t   result
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PRE  = 4'd1;
    localparam logic [3:0] ST_COEF = 4'd2;
    localparam logic [3:0] ST_CYL  = 4'd3;
    localparam logic [3:0] ST_P1   = 4'd4;
    localparam logic [3:0] ST_P2   = 4'd5;
    localparam logic [3:0] ST_QSEL = 4'd6;
    localparam logic [3:0] ST_D0   = 4'd7;
    localparam logic [3:0] ST_D1   = 4'd8;
    localparam logic [3:0] ST_D2   = 4'd9;
    localparam logic [3:0] ST_D3   = 4'd10;
    localparam logic [3:0] ST_SQ   = 4'd11;
    localparam logic [3:0] ST_DV   = 4'd12;
    localparam logic [3:0] ST_Y0   = 4'd13;
    localparam logic [3:0] ST_Y1   = 4'd14;
    localparam logic [3:0] ST_DONE = 4'd15;

    localparam logic [1:0] SURF_CYL = 2'd0;
    localparam logic [1:0] SURF_LO  = 2'd1;
    localparam logic [1:0] SURF_HI  = 2'd2;

    localparam int PRE_OPS = 12;
    localparam logic signed [34:0] T_HUGE = 35'sd2147483648;

    logic [3:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] sel_reg, sel_next;
    logic       root_reg, root_next;
    logic       found_reg, found_next;
    logic       done_reg, done_next;
    ctri_pkg::ctri_result_t res_reg, res_next;

    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic signed [31:0] dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [30:0]        maxd_reg, maxd_next;
    logic signed [31:0] soy0_reg, soy0_next, soy1_reg, soy1_next;
    logic signed [47:0] qm_reg [PRE_OPS];
    logic signed [47:0] qm_next [PRE_OPS];
    logic signed [31:0] a_reg, a_next, sa_reg, sa_next, hb_reg, hb_next, c_reg, c_next;
    logic signed [31:0] shb0_reg, shb0_next, sc0_reg, sc0_next;
    logic signed [31:0] shb1_reg, shb1_next, sc1_reg, sc1_next;
    logic signed [31:0] qa_reg, qa_next, qhb_reg, qhb_next, qc_reg, qc_next;
    logic signed [64:0] dsc_reg, dsc_next;
    logic [31:0]        s_reg, s_next;
    logic signed [34:0] t_reg, t_next, t0_reg, t0_next, best_reg, best_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] p_reg;

    logic               dv_start, dv_done;
    logic signed [33:0] dv_num;
    logic signed [31:0] dv_den;
    logic signed [34:0] dv_quo;
    logic               sq_start, sq_done;
    logic [31:0]        sq_root;

    logic               next_surf;
    logic [3:0]         pidx;
    logic signed [34:0] tc;
    logic signed [34:0] tmin, tmax;
    logic signed [48:0] ycyl;
    logic signed [30:0] hh_s;
    logic signed [48:0] hh49;
    logic signed [33:0] hh34;
    logic signed [33:0] s34;
    logic               hit_w;

    ctri_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    ctri_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (dsc_reg[63:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign hh_s = {1'b0, half_h};
    assign hh49 = 49'(hh_s);
    assign hh34 = 34'(hh_s);
    assign s34  = $signed({2'b00, s_reg});
    assign pidx = step_reg - 4'd1;
    assign tc   = (dv_quo > T_HUGE) ? T_HUGE : ((dv_quo < -T_HUGE) ? -T_HUGE : dv_quo);
    assign tmin = (t0_reg > dv_quo) ? dv_quo : t0_reg;
    assign tmax = (t0_reg > dv_quo) ? t0_reg : dv_quo;
    assign ycyl = 49'(oy_reg) + 49'($signed(p_reg[63:16]));
    assign hit_w = found_reg && !best_reg[34] && (best_reg <= $signed({4'b0, maxd_reg}));

    assign done   = done_reg;
    assign result = res_reg;

    // shared multiplier, product registered
    always_ff @(posedge clk) begin
        p_reg <= mul_a * mul_b;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        root_next  = root_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        maxd_next  = maxd_reg;
        soy0_next  = soy0_reg;
        soy1_next  = soy1_reg;
        qm_next    = qm_reg;
        a_next     = a_reg;
        sa_next    = sa_reg;
        hb_next    = hb_reg;
        c_next     = c_reg;
        shb0_next  = shb0_reg;
        sc0_next   = sc0_reg;
        shb1_next  = shb1_reg;
        sc1_next   = sc1_reg;
        qa_next    = qa_reg;
        qhb_next   = qhb_reg;
        qc_next    = qc_reg;
        dsc_next   = dsc_reg;
        s_next     = s_reg;
        t_next     = t_reg;
        t0_next    = t0_reg;
        best_next  = best_reg;
        mul_a      = '0;
        mul_b      = '0;
        dv_start   = 1'b0;
        dv_num     = '0;
        dv_den     = '0;
        sq_start   = 1'b0;
        pop        = 1'b0;
        next_surf  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    pop = 1'b1;
                    if (!q_job.ray) begin
                        done_next        = 1'b1;
                        res_next.ok      = q_job.ok;
                        res_next.hit     = 1'b0;
                        res_next.distance = '0;
                    end else begin
                        ox_next    = q_job.ox;
                        oy_next    = q_job.oy;
                        oz_next    = q_job.oz;
                        dx_next    = q_job.dx;
                        dy_next    = q_job.dy;
                        dz_next    = q_job.dz;
                        maxd_next  = q_job.max_dist;
                        soy0_next  = ctri_pkg::sat32(52'(q_job.oy) + 52'(hh_s));
                        soy1_next  = ctri_pkg::sat32(52'(q_job.oy) - 52'(hh_s));
                        step_next  = '0;
                        found_next = 1'b0;
                        best_next  = '0;
                        state_next = ST_PRE;
                    end
                end
            end
            ST_PRE: begin
                if (step_reg != 4'd0) begin
                    qm_next[pidx] = p_reg[63:16];
                end
                unique case (step_reg)
                    4'd0:  begin mul_a = $signed({2'b00, radius}); mul_b = mul_a; end
                    4'd1:  begin mul_a = 33'(dx_reg);   mul_b = 33'(dx_reg);   end
                    4'd2:  begin mul_a = 33'(dy_reg);   mul_b = 33'(dy_reg);   end
                    4'd3:  begin mul_a = 33'(dz_reg);   mul_b = 33'(dz_reg);   end
                    4'd4:  begin mul_a = 33'(ox_reg);   mul_b = 33'(dx_reg);   end
                    4'd5:  begin mul_a = 33'(oz_reg);   mul_b = 33'(dz_reg);   end
                    4'd6:  begin mul_a = 33'(ox_reg);   mul_b = 33'(ox_reg);   end
                    4'd7:  begin mul_a = 33'(oz_reg);   mul_b = 33'(oz_reg);   end
                    4'd8:  begin mul_a = 33'(soy0_reg); mul_b = 33'(dy_reg);   end
                    4'd9:  begin mul_a = 33'(soy0_reg); mul_b = 33'(soy0_reg); end
                    4'd10: begin mul_a = 33'(soy1_reg); mul_b = 33'(dy_reg);   end
                    4'd11: begin mul_a = 33'(soy1_reg); mul_b = 33'(soy1_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                if (step_reg == 4'(PRE_OPS)) begin
                    state_next = ST_COEF;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_COEF: begin
                a_next    = ctri_pkg::sat32(52'(qm_reg[1]) + 52'(qm_reg[3]));
                sa_next   = ctri_pkg::sat32(52'(qm_reg[1]) + 52'(qm_reg[2]) + 52'(qm_reg[3]));
                hb_next   = ctri_pkg::sat32(52'(qm_reg[4]) + 52'(qm_reg[5]));
                c_next    = ctri_pkg::sat32(52'(qm_reg[6]) + 52'(qm_reg[7]) - 52'(qm_reg[0]));
                shb0_next = ctri_pkg::sat32(52'(qm_reg[4]) + 52'(qm_reg[8]) + 52'(qm_reg[5]));
                sc0_next  = ctri_pkg::sat32(52'(qm_reg[6]) + 52'(qm_reg[9]) + 52'(qm_reg[7])
                                            - 52'(qm_reg[0]));
                shb1_next = ctri_pkg::sat32(52'(qm_reg[4]) + 52'(qm_reg[10]) + 52'(qm_reg[5]));
                sc1_next  = ctri_pkg::sat32(52'(qm_reg[6]) + 52'(qm_reg[11]) + 52'(qm_reg[7])
                                            - 52'(qm_reg[0]));
                state_next = ST_CYL;
            end
            ST_CYL: begin
                if (a_reg == 32'sd0) begin
                    // ray runs along the axis: clip against the flat ends only
                    if (c_reg > 32'sd0 || dy_reg == 32'sd0) begin
                        state_next = ST_DONE;
                    end else begin
                        dv_start   = 1'b1;
                        dv_num     = -hh34 - 34'(oy_reg);
                        dv_den     = dy_reg;
                        state_next = ST_P1;
                    end
                end else begin
                    sel_next   = SURF_CYL;
                    state_next = ST_QSEL;
                end
            end
            ST_P1: begin
                if (dv_done) begin
                    t0_next    = dv_quo;
                    dv_start   = 1'b1;
                    dv_num     = hh34 - 34'(oy_reg);
                    dv_den     = dy_reg;
                    state_next = ST_P2;
                end
            end
            ST_P2: begin
                if (dv_done) begin
                    if (tmin > 35'sd0) begin
                        found_next = 1'b1;
                        best_next  = tmin;
                    end else if (tmax > 35'sd0) begin
                        found_next = 1'b1;
                        best_next  = tmax;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_QSEL: begin
                root_next = 1'b0;
                if (sel_reg == SURF_CYL) begin
                    qa_next    = a_reg;
                    qhb_next   = hb_reg;
                    qc_next    = c_reg;
                    state_next = ST_D0;
                end else if (sa_reg == 32'sd0) begin
                    next_surf = 1'b1;
                end else begin
                    qa_next    = sa_reg;
                    qhb_next   = (sel_reg == SURF_LO) ? shb0_reg : shb1_reg;
                    qc_next    = (sel_reg == SURF_LO) ? sc0_reg : sc1_reg;
                    state_next = ST_D0;
                end
            end
            ST_D0: begin
                mul_a      = 33'(qhb_reg);
                mul_b      = 33'(qhb_reg);
                state_next = ST_D1;
            end
            ST_D1: begin
                dsc_next   = p_reg[64:0];
                mul_a      = 33'(qa_reg);
                mul_b      = 33'(qc_reg);
                state_next = ST_D2;
            end
            ST_D2: begin
                dsc_next   = dsc_reg - $signed(p_reg[64:0]);
                state_next = ST_D3;
            end
            ST_D3: begin
                if (dsc_reg[64]) begin
                    next_surf = 1'b1;
                end else begin
                    sq_start   = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (sq_done) begin
                    s_next     = sq_root;
                    dv_start   = 1'b1;
                    dv_num     = -34'(qhb_reg) - $signed({2'b00, sq_root});
                    dv_den     = qa_reg;
                    state_next = ST_DV;
                end
            end
            ST_DV: begin
                if (dv_done) begin
                    if (sel_reg == SURF_CYL) begin
                        t_next     = tc;
                        state_next = ST_Y0;
                    end else begin
                        if (tc > 35'sd0 && (!found_reg || tc < best_reg)) begin
                            found_next = 1'b1;
                            best_next  = tc;
                        end
                        next_surf = 1'b1;
                    end
                end
            end
            ST_Y0: begin
                mul_a      = 33'(dy_reg);
                mul_b      = t_reg[32:0];
                state_next = ST_Y1;
            end
            ST_Y1: begin
                if (!t_reg[34] && ycyl >= -hh49 && ycyl <= hh49) begin
                    found_next = 1'b1;
                    best_next  = t_reg;
                    next_surf  = 1'b1;
                end else if (!root_reg) begin
                    root_next  = 1'b1;
                    dv_start   = 1'b1;
                    dv_num     = -34'(qhb_reg) + s34;
                    dv_den     = qa_reg;
                    state_next = ST_DV;
                end else begin
                    next_surf = 1'b1;
                end
            end
            ST_DONE: begin
                done_next         = 1'b1;
                res_next.ok       = 1'b1;
                res_next.hit      = hit_w;
                res_next.distance = hit_w ? best_reg[30:0] : 31'd0;
                state_next        = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (next_surf) begin
            if (sel_reg == SURF_HI) begin
                state_next = ST_DONE;
            end else begin
                sel_next   = sel_reg + 2'd1;
                state_next = ST_QSEL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        step_reg  <= step_next;
        sel_reg   <= sel_next;
        root_reg  <= root_next;
        found_reg <= found_next;
        res_reg   <= res_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dz_reg    <= dz_next;
        maxd_reg  <= maxd_next;
        soy0_reg  <= soy0_next;
        soy1_reg  <= soy1_next;
        qm_reg    <= qm_next;
        a_reg     <= a_next;
        sa_reg    <= sa_next;
        hb_reg    <= hb_next;
        c_reg     <= c_next;
        shb0_reg  <= shb0_next;
        sc0_reg   <= sc0_next;
        shb1_reg  <= shb1_next;
        sc1_reg   <= sc1_next;
        qa_reg    <= qa_next;
        qhb_reg   <= qhb_next;
        qc_reg    <= qc_next;
        dsc_reg   <= dsc_next;
        s_reg     <= s_next;
        t_reg     <= t_next;
        t0_reg    <= t0_next;
        best_reg  <= best_next;
    end

endmodule
`default_nettype wire

// ----- rtl/capsule_table_ray_intersect.sv -----
// Create/destroy/move and a raycast on a bad or inactive slot pass the front stage and the
// queue and are answered straight from the sequencer's idle state. A raycast on an active
// slot runs 13 setup multiply steps, then either ends (ray along the axis, outside the
// radius) or goes on through up to three square roots and up to four divisions. The front
// takes a new request only once the last has moved into the 4-entry queue, and not while the
// queue is full; the back end sets the sustained raycast rate. Reset (rst_n low, async):
// table marks cleared, queue and sequencer idle, radius 1.0 and height 2.0; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module capsule_table_ray_intersect #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire ctri_pkg::ctri_request_t request,
    output logic                         done,
    output ctri_pkg::ctri_result_t       result,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [31:0]             cfg_data
);

    // Front: slot table lookup/update and origin offsets, one request in flight.
    // Queue: classified jobs, so the table keeps taking requests while a raycast runs.
    // Back: sequencer with one shared 33x33 multiplier, a bit-serial divider
    // and a two-bit-per-step square root.

    logic [30:0] radius_reg;
    logic [30:0] height_reg;
    logic [29:0] half_h;

    logic                push;
    ctri_pkg::ctri_job_t push_job;
    logic                pop;
    ctri_pkg::ctri_job_t head_job;
    logic                q_empty;
    logic                q_full;

    assign cfg_ready = 1'b1;
    assign half_h    = height_reg[30:1];

    // registers must change only while idle (the user's duty; the block does not enforce it), so no shadowing is needed
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            radius_reg <= ctri_pkg::RADIUS_RESET;
            height_reg <= ctri_pkg::HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == ctri_pkg::CFG_RADIUS) begin
                radius_reg <= cfg_data[30:0];
            end else if (cfg_index == ctri_pkg::CFG_HEIGHT) begin
                height_reg <= cfg_data[30:0];
            end
        end
    end

    ctri_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .half_h   (half_h),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    ctri_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    ctri_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (head_job),
        .pop     (pop),
        .radius  (radius_reg),
        .half_h  (half_h),
        .done    (done),
        .result  (result)
    );

    `ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !q_full || pop, "queue overflow")
    `ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !q_empty, "queue underflow")
    `ASSERT_IMPLY(a_hit_ok, clk, rst_n, done && result.hit, result.ok, "hit without ok")
    `ASSERT_IMPLY(a_miss_zero, clk, rst_n, done && !result.hit, result.distance == '0, "miss")

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam longint Q1 = 65536;          // 1.0 in Q16.16
    localparam int     SLOT_COUNT = 16;
    localparam int     PHASE_LEN = 250;
    // config indexes the block does not decode; writes there must be ignored
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef enum {STEP_REQ, STEP_CFG, STEP_DRAIN} step_kind_t;
    typedef struct {
        step_kind_t              kind;
        ctri_pkg::ctri_request_t req;
        logic [1:0]              idx;
        logic [31:0]             data;
    } step_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    ctri_pkg::ctri_request_t request;
    logic                    done;
    ctri_pkg::ctri_result_t  result;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_index;
    logic [31:0]             cfg_data;

    capsule_table_ray_intersect dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the capsule table and registers (predictor side)
    // ---------------------------------------------------------------
    longint shadow_x [SLOT_COUNT];
    longint shadow_y [SLOT_COUNT];
    longint shadow_z [SLOT_COUNT];
    bit     shadow_live [SLOT_COUNT];
    longint radius_q = 65536;
    longint height_q = 131072;

    step_t                  plan [$];       // pending stimulus for the driver
    ctri_pkg::ctri_result_t awaited [$];    // predicted results, oldest first

    int req_issued, req_accepts, cfg_issued, cfg_accepts;
    int mismatches, ray_count, hit_count, phase_count;

    // planning-side copy of bases so rays can be aimed at capsules
    longint aim_x [SLOT_COUNT];
    longint aim_y [SLOT_COUNT];
    longint aim_z [SLOT_COUNT];
    longint aim_height = 131072;

    function automatic longint clip_s32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_dist(input longint v);
        if (v > 64'sd2147483648)
            return 64'sd2147483648;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor(a*b / 2^16); arithmetic shift floors negatives
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    // truncating Q16.16 divide
    function automatic longint fx_div(input longint n, input longint d);
        return (n * Q1) / d;
    endfunction

    function automatic longint root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // nearest positive hit on the capsule in slot s; returns 1 on a hit
    function automatic bit trace_capsule(input int s, input longint o0, input longint o1,
                                         input longint o2, input longint d0,
                                         input longint d1, input longint d2,
                                         output longint hit_t);
        longint hh, ox, oy, oz, rr, a, hb, c, t0, t1, tmp, disc, sq, t, y;
        longint cap_y, soy, sa, shb, sc, sdisc, st, best;
        longint roots [2];
        bit found;
        hit_t = 0;
        found = 0;
        best = 0;
        hh = height_q >>> 1;
        ox = clip_s32(o0 - shadow_x[s]);
        oy = clip_s32(o1 - shadow_y[s] - hh);
        oz = clip_s32(o2 - shadow_z[s]);
        rr = fx_mul(radius_q, radius_q);
        a  = clip_s32(fx_mul(d0, d0) + fx_mul(d2, d2));
        hb = clip_s32(fx_mul(ox, d0) + fx_mul(oz, d2));
        c  = clip_s32(fx_mul(ox, ox) + fx_mul(oz, oz) - rr);

        // ray parallel to the axis: clip against the two flat planes only
        if (a == 0) begin
            if (c > 0 || d1 == 0)
                return 0;
            t0 = fx_div(-hh - oy, d1);
            t1 = fx_div(hh - oy, d1);
            if (t0 > t1) begin
                tmp = t0;
                t0 = t1;
                t1 = tmp;
            end
            if (t0 > 0) begin
                hit_t = t0;
                return 1;
            end
            if (t1 > 0) begin
                hit_t = t1;
                return 1;
            end
            return 0;
        end

        // side wall: first non-negative root inside the wall height
        disc = hb * hb - a * c;
        if (disc >= 0) begin
            sq = root_floor(disc);
            roots[0] = clip_dist(fx_div(-hb - sq, a));
            roots[1] = clip_dist(fx_div(-hb + sq, a));
            for (int k = 0; k < 2; k++) begin
                t = roots[k];
                if (t >= 0 && !found) begin
                    y = oy + fx_mul(d1, t);
                    if (y >= -hh && y <= hh) begin
                        best = t;
                        found = 1;
                    end
                end
            end
        end

        // end spheres, near root only
        for (int k = 0; k < 2; k++) begin
            cap_y = (k == 0) ? -hh : hh;
            soy = clip_s32(oy - cap_y);
            sa  = clip_s32(fx_mul(d0, d0) + fx_mul(d1, d1) + fx_mul(d2, d2));
            shb = clip_s32(fx_mul(ox, d0) + fx_mul(soy, d1) + fx_mul(oz, d2));
            sc  = clip_s32(fx_mul(ox, ox) + fx_mul(soy, soy) + fx_mul(oz, oz) - rr);
            if (sa != 0) begin
                sdisc = shb * shb - sa * sc;
                if (sdisc >= 0) begin
                    st = clip_dist(fx_div(-shb - root_floor(sdisc), sa));
                    if (st > 0 && (!found || st < best)) begin
                        best = st;
                        found = 1;
                    end
                end
            end
        end
        hit_t = best;
        return found;
    endfunction

    // applies one request to the shadow table and returns its result
    function automatic ctri_pkg::ctri_result_t forecast_result(
        input ctri_pkg::ctri_request_t q);
        ctri_pkg::ctri_result_t r;
        longint t;
        int s;
        r = '0;
        s = q.slot;
        case (q.opcode)
            ctri_pkg::OP_CREATE: begin
                shadow_x[s] = longint'($signed(q.pos_x));
                shadow_y[s] = longint'($signed(q.pos_y));
                shadow_z[s] = longint'($signed(q.pos_z));
                shadow_live[s] = 1;
                r.ok = 1;
            end
            ctri_pkg::OP_DESTROY: begin
                shadow_live[s] = 0;
                r.ok = 1;
            end
            ctri_pkg::OP_MOVE: begin
                if (shadow_live[s]) begin
                    shadow_x[s] = longint'($signed(q.pos_x));
                    shadow_y[s] = longint'($signed(q.pos_y));
                    shadow_z[s] = longint'($signed(q.pos_z));
                    r.ok = 1;
                end
            end
            default: begin
                if (shadow_live[s]) begin
                    r.ok = 1;
                    if (trace_capsule(s, longint'($signed(q.origin_x)),
                                      longint'($signed(q.origin_y)),
                                      longint'($signed(q.origin_z)),
                                      longint'($signed(q.dir_x)),
                                      longint'($signed(q.dir_y)),
                                      longint'($signed(q.dir_z)), t)
                        && t >= 0 && t <= longint'(q.max_dist)) begin
                        r.hit = 1;
                        r.distance = t[30:0];
                    end
                end
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus planning helpers
    // ---------------------------------------------------------------
    function automatic longint pick(input longint lo, input longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    task automatic push_op(input logic [1:0] op, input int s,
                           input longint px, input longint py, input longint pz,
                           input longint ox, input longint oy, input longint oz,
                           input longint dx, input longint dy, input longint dz,
                           input logic [30:0] md);
        step_t st;
        st.kind = STEP_REQ;
        st.idx = '0;
        st.data = '0;
        st.req.opcode = op;
        st.req.slot = s[3:0];
        st.req.pos_x = px[31:0];
        st.req.pos_y = py[31:0];
        st.req.pos_z = pz[31:0];
        st.req.origin_x = ox[31:0];
        st.req.origin_y = oy[31:0];
        st.req.origin_z = oz[31:0];
        st.req.dir_x = dx[31:0];
        st.req.dir_y = dy[31:0];
        st.req.dir_z = dz[31:0];
        st.req.max_dist = md;
        if (op == ctri_pkg::OP_CREATE || op == ctri_pkg::OP_MOVE) begin
            aim_x[s] = longint'($signed(px[31:0]));
            aim_y[s] = longint'($signed(py[31:0]));
            aim_z[s] = longint'($signed(pz[31:0]));
        end
        plan.push_back(st);
    endtask

    task automatic push_cfg(input logic [1:0] idx, input logic [31:0] data);
        step_t st;
        st.kind = STEP_CFG;
        st.req = '0;
        st.idx = idx;
        st.data = data;
        if (idx == ctri_pkg::CFG_HEIGHT)
            aim_height = longint'(data[30:0]);
        plan.push_back(st);
    endtask

    task automatic push_drain();
        step_t st;
        st.kind = STEP_DRAIN;
        st.req = '0;
        st.idx = '0;
        st.data = '0;
        plan.push_back(st);
    endtask

    // ray aimed near the capsule in slot s, with random content
    task automatic push_aimed_ray(input int s);
        longint tx, ty, tz, ox, oy, oz, dx, dy, dz, hspan;
        int sh;
        logic [30:0] md;
        hspan = (aim_height > 8 * Q1) ? 8 * Q1 : aim_height;
        tx = aim_x[s] + pick(-2 * Q1, 2 * Q1);
        ty = aim_y[s] + pick(-Q1, hspan + Q1);
        tz = aim_z[s] + pick(-2 * Q1, 2 * Q1);
        if ($urandom_range(0, 3) == 0) begin
            // straight up or down the axis region
            ox = tx;
            oz = tz;
            oy = ty + pick(-10 * Q1, 10 * Q1);
            dx = 0;
            dz = 0;
            dy = pick(-4 * Q1, 4 * Q1);
        end else begin
            ox = tx + pick(-10 * Q1, 10 * Q1);
            oy = ty + pick(-10 * Q1, 10 * Q1);
            oz = tz + pick(-10 * Q1, 10 * Q1);
            sh = $urandom_range(0, 3);
            dx = (tx - ox) >>> sh;
            dy = (ty - oy) >>> sh;
            dz = (tz - oz) >>> sh;
        end
        case ($urandom_range(0, 9))
            0, 1:    md = 31'($urandom_range(0, 16 * Q1));
            2:       md = 31'($urandom);
            default: md = 31'($urandom_range(64 * Q1, 32'h7fffffff));
        endcase
        push_op(ctri_pkg::OP_RAY, s, 0, 0, 0, ox, oy, oz, dx, dy, dz, md);
    endtask

    task automatic push_random_phase(input int n);
        int s;
        int r;
        for (int i = 0; i < n; i++) begin
            s = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            r = $urandom_range(0, 99);
            if (r < 12) begin
                // noise: opcode and all data fields fully random
                push_op(2'($urandom), s, int'($urandom), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom), int'($urandom), 31'($urandom));
            end else if (r < 27) begin
                push_op(ctri_pkg::OP_CREATE, s, pick(-20 * Q1, 20 * Q1),
                        pick(-20 * Q1, 20 * Q1), pick(-20 * Q1, 20 * Q1),
                        0, 0, 0, 0, 0, 0, 0);
            end else if (r < 33) begin
                push_op(ctri_pkg::OP_DESTROY, s, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
            end else if (r < 42) begin
                push_op(ctri_pkg::OP_MOVE, s, pick(-20 * Q1, 20 * Q1),
                        pick(-20 * Q1, 20 * Q1), pick(-20 * Q1, 20 * Q1),
                        0, 0, 0, 0, 0, 0, 0);
            end else begin
                push_aimed_ray(s);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Clock, reset, watchdog
    // ---------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #60ms;
        $display("timeout: %0d results still outstanding", awaited.size());
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: one step per falling edge unless held or idling, request and config channels
    // ---------------------------------------------------------------
    int gap_left;
    int calm_left;      // requests left in a stretch with no idling
    int idle_left;      // requests left in a stretch with idling

    always @(negedge clk) begin : drive
        logic nxt_start;
        logic nxt_cfg;
        int r;
        nxt_start = start;
        nxt_cfg = cfg_valid;
        if (rst_n) begin
            if (start && req_accepts != req_issued) begin
                // request still waiting for busy to drop
            end else if (cfg_valid && cfg_accepts != cfg_issued) begin
                nxt_start = 1'b0;
            end else begin
                nxt_start = 1'b0;
                nxt_cfg = 1'b0;
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (plan.size() != 0) begin
                    case (plan[0].kind)
                        STEP_REQ: begin
                            nxt_start = 1'b1;
                            request <= plan[0].req;
                            req_issued = req_issued + 1;
                            void'(plan.pop_front());
                            if (calm_left == 0 && idle_left == 0) begin
                                if ($urandom_range(0, 1))
                                    calm_left = $urandom_range(10, 60);
                                else
                                    idle_left = $urandom_range(10, 60);
                            end
                            if (calm_left > 0) begin
                                calm_left = calm_left - 1;
                                gap_left = 0;
                            end else begin
                                idle_left = idle_left - 1;
                                r = $urandom_range(0, 99);
                                gap_left = (r < 50) ? 0 :
                                           (r < 90) ? $urandom_range(1, 4) :
                                                      $urandom_range(20, 150);
                            end
                        end
                        STEP_CFG: begin
                            // registers change only with nothing in flight
                            if (awaited.size() == 0 && !start) begin
                                nxt_cfg = 1'b1;
                                cfg_index <= plan[0].idx;
                                cfg_data <= plan[0].data;
                                cfg_issued = cfg_issued + 1;
                                void'(plan.pop_front());
                            end
                        end
                        default: begin
                            if (awaited.size() == 0 && !start)
                                void'(plan.pop_front());
                        end
                    endcase
                end
            end
        end
        start <= nxt_start;
        cfg_valid <= nxt_cfg;
    end

    // ---------------------------------------------------------------
    // Monitor: results checked against the oldest prediction, accepted
    // requests and register writes fed to the shadow model
    // ---------------------------------------------------------------
    always @(posedge clk) begin : watch
        ctri_pkg::ctri_result_t want;
        if (rst_n) begin
            if (done) begin
                if (awaited.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%t: result with nothing outstanding: ok=%0d hit=%0d dist=%0d",
                                 $realtime, result.ok, result.hit, result.distance);
                end else begin
                    want = awaited.pop_front();
                    if (want.hit)
                        hit_count = hit_count + 1;
                    if (result.ok !== want.ok || result.hit !== want.hit
                        || result.distance !== want.distance) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%t: mismatch ok=%0d/%0d hit=%0d/%0d dist=%0d/%0d %s",
                                     $realtime, result.ok, want.ok, result.hit, want.hit,
                                     result.distance, want.distance, "(got/expected)");
                    end
                end
            end
            if (start && !busy) begin
                if (request.opcode == ctri_pkg::OP_RAY)
                    ray_count = ray_count + 1;
                awaited.push_back(forecast_result(request));
                req_accepts = req_accepts + 1;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ctri_pkg::CFG_RADIUS)
                    radius_q = longint'(cfg_data[30:0]);
                else if (cfg_index == ctri_pkg::CFG_HEIGHT)
                    height_q = longint'(cfg_data[30:0]);
                cfg_accepts = cfg_accepts + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin : sequence_main
        logic [31:0] radii [7];
        logic [31:0] heights [7];
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            shadow_x[i] = 0;
            shadow_y[i] = 0;
            shadow_z[i] = 0;
            shadow_live[i] = 0;
            aim_x[i] = 0;
            aim_y[i] = 0;
            aim_z[i] = 0;
        end

        // undecoded indexes first, then directed checks at reset geometry
        push_cfg(CFG_SPARE_A, 32'hffff_ffff);
        push_cfg(CFG_SPARE_B, 32'h0000_0001);
        // inactive slot: ray and move refused, destroy still ok
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, -5 * Q1, Q1, 0, Q1, 0, 0, 31'h7fffffff);
        push_op(ctri_pkg::OP_MOVE, 0, Q1, Q1, Q1, 0, 0, 0, 0, 0, 0, 0);
        push_op(ctri_pkg::OP_DESTROY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_op(ctri_pkg::OP_CREATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_op(ctri_pkg::OP_CREATE, 15, 32'sh7fffffff, -64'sd2147483648, 32'sh7fffffff,
                0, 0, 0, 0, 0, 0, 0);
        // side wall hit at 4.0, then max_dist just at and below it
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, -5 * Q1, Q1, 0, Q1, 0, 0, 31'h7fffffff);
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, -5 * Q1, Q1, 0, Q1, 0, 0, 31'(4 * Q1));
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, -5 * Q1, Q1, 0, Q1, 0, 0, 31'(4 * Q1 - 1));
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, -5 * Q1, Q1, 0, Q1, 0, 0, 31'd0);
        // parallel to axis: plane clip, zero direction, outside radius
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, 0, 10 * Q1, 0, 0, -Q1, 0, 31'h7fffffff);
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, 0, Q1, 0, 0, 0, 0, 31'h7fffffff);
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, 5 * Q1, 10 * Q1, 0, 0, -Q1, 0, 31'h7fffffff);
        // top sphere, clean miss, pointing away, starting inside
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, -5 * Q1, 5 * Q1 / 2, 0, Q1, 0, 0,
                31'h7fffffff);
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, -5 * Q1, Q1, 5 * Q1, Q1, 0, 0, 31'h7fffffff);
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, -5 * Q1, Q1, 0, -Q1, 0, 0, 31'h7fffffff);
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, 0, Q1, 0, Q1, Q1 / 4, 0, 31'h7fffffff);
        // move then overwrite by create on an active slot
        push_op(ctri_pkg::OP_MOVE, 0, 3 * Q1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_op(ctri_pkg::OP_RAY, 0, 0, 0, 0, -5 * Q1, Q1, 0, 2 * Q1, 0, 0, 31'h7fffffff);
        push_op(ctri_pkg::OP_CREATE, 0, 0, -Q1, 0, 0, 0, 0, 0, 0, 0, 0);
        // saturating extremes against the far-out capsule
        push_op(ctri_pkg::OP_RAY, 15, 0, 0, 0, -64'sd2147483648, 32'sh7fffffff,
                -64'sd2147483648, 32'sh7fffffff, -64'sd2147483648, 32'sh7fffffff,
                31'h7fffffff);
        push_op(ctri_pkg::OP_RAY, 15, 0, 0, 0, 32'sh7fffffff, -64'sd2147483648,
                32'sh7fffffff, -64'sd2147483648, 32'sh7fffffff, -64'sd2147483648,
                31'h7fffffff);
        push_op(ctri_pkg::OP_DESTROY, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_op(ctri_pkg::OP_RAY, 15, 0, 0, 0, 0, 0, 0, Q1, 0, 0, 31'h7fffffff);

        // register settings per phase, extremes among them
        radii[0] = 32'(Q1);          heights[0] = 32'(2 * Q1);
        radii[1] = 32'd0;            heights[1] = 32'd0;
        radii[2] = 32'hffff_ffff;    heights[2] = 32'h7fff_ffff;
        radii[3] = 32'(Q1 / 2);      heights[3] = 32'(4 * Q1);
        radii[4] = $urandom_range(0, 4 * Q1);
        heights[4] = $urandom_range(0, 8 * Q1);
        radii[5] = 32'(3 * Q1);      heights[5] = 32'(Q1 / 4);
        radii[6] = $urandom;         heights[6] = $urandom;
        for (int p = 0; p < 7; p++) begin
            push_drain();
            push_cfg(ctri_pkg::CFG_RADIUS, radii[p]);
            push_cfg(ctri_pkg::CFG_HEIGHT, heights[p]);
            // a few creates so the rays have targets
            for (int s = 0; s < 4; s++)
                push_op(ctri_pkg::OP_CREATE, s, pick(-20 * Q1, 20 * Q1),
                        pick(-20 * Q1, 20 * Q1), pick(-20 * Q1, 20 * Q1),
                        0, 0, 0, 0, 0, 0, 0);
            push_random_phase(PHASE_LEN);
        end
        phase_count = 7;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (plan.size() == 0 && !start && !cfg_valid && req_accepts == req_issued);
        wait (awaited.size() == 0);
        repeat (400) @(posedge clk);

        $display("covered %0d requests, %0d raycasts (%0d hits) over %0d register settings",
                 req_accepts, ray_count, hit_count, phase_count);
        $display("%0d mismatches, %0d results left outstanding", mismatches, awaited.size());
        if (mismatches == 0 && awaited.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
